### rtl/core/serial_eeprom_shift_master_macros.svh
// Assertion macros shared by the serial EEPROM shift master RTL.
`ifndef SERIAL_EEPROM_SHIFT_MASTER_MACROS_SVH
`define SERIAL_EEPROM_SHIFT_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SESM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sesm_pkg.sv
// Shared types and constants of the serial EEPROM shift master.
`default_nettype none

package sesm_pkg;

  localparam int MAX_BITS = 16;
  localparam int CMD_W    = 16;
  localparam int CNT_W    = 5;
  localparam int TICK_W   = 16;

  // Bit positions inside the pin level vector.
  localparam int PIN_SK = 0;
  localparam int PIN_DI = 1;
  localparam int PIN_CE = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic             start_req;
    logic [CMD_W-1:0] command_word;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_count;
    logic             serial_data_out;
  } item_t;

  typedef struct packed {
    logic             serial_clock;
    logic             serial_data_in;
    logic             chip_enable;
    logic             busy_res;
    logic             done_res;
    logic [CMD_W-1:0] read_value;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/serial_eeprom_shift_master.sv
// Top level of the serial EEPROM shift master with its stream ports.
`default_nettype none
`include "serial_eeprom_shift_master_macros.svh"

// Serial EEPROM shift master. Every input transaction is one tick of time and
// produces exactly one output transaction with the pin levels after that tick,
// the busy flag, and on the last tick of an EEPROM access the done flag (tlast)
// with the bits read. A start request in idle latches the command word and
// the write and read bit counts (each capped at 16); the master then raises
// chip enable, sends the command least significant bit first with one clock
// pulse per bit, holds data-in high, reads the response least significant bit
// first, and finally drops chip enable. Each pin phase lasts cfg phase_ticks
// ticks (zero acts as one). Starts while busy are ignored. The block accepts
// one input transaction per clock cycle; an item passes an input register and
// the sequencer update into the output register, and the rate is set only by
// the downstream tready. Write the configuration register only while no input
// is pending.
module serial_eeprom_shift_master (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration: phase_ticks.
  input  wire logic                              cfg_we,
  input  wire logic [sesm_pkg::TICK_W-1:0]       cfg_wdata,
  // Input tick stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata from bit 0: command_word[16], write_count[5], read_count[5],
  // serial_data_out[1], zero padding[5].
  input  wire logic [sesm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: start_req[1].
  input  wire logic                              in_tuser,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata from bit 0: serial_clock[1], serial_data_in[1], chip_enable[1],
  // busy_res[1], read_value[16], zero padding[4].
  output logic [sesm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // tlast: done_res, high on the tick that ends an EEPROM access.
  output logic                                   out_tlast
);
  import sesm_pkg::*;

  logic    in_v_r, in_v_nxt;
  item_t   in_item_r;
  logic    out_v_r, out_v_nxt;
  result_t out_res_r;
  result_t seq_res;
  logic    out_free;
  logic    step;

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !out_v_r || out_tready;
  assign step      = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.start_req       <= in_tuser;
      in_item_r.command_word    <= in_tdata[15:0];
      in_item_r.write_count     <= in_tdata[20:16];
      in_item_r.read_count      <= in_tdata[25:21];
      in_item_r.serial_data_out <= in_tdata[26];
    end
    if (step) begin
      out_res_r <= seq_res;
    end
  end

  sesm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_i    (step),
    .item_i    (in_item_r),
    .res_o     (seq_res)
  );

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_res_r.done_res;
  assign out_tdata  = {4'b0000, out_res_r.read_value, out_res_r.busy_res,
                       out_res_r.chip_enable, out_res_r.serial_data_in,
                       out_res_r.serial_clock};

  `SESM_ASSERT_IMPLIES(a_done_not_busy, out_tvalid && out_tlast,
                       !out_res_r.busy_res && !out_res_r.chip_enable,
                       "done reported while still busy")
  `SESM_ASSERT_IMPLIES(a_value_only_on_done, out_tvalid && !out_tlast,
                       out_res_r.read_value == '0, "read value outside done tick")
endmodule

`default_nettype wire

### rtl/core/sesm_seq.sv
// Phase sequencer: transaction state and the per-tick next-state logic.
`default_nettype none
`include "serial_eeprom_shift_master_macros.svh"

module sesm_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sesm_pkg::TICK_W-1:0]   cfg_wdata,
  input  wire logic                          step_i,
  input  wire sesm_pkg::item_t               item_i,
  output sesm_pkg::result_t                  res_o
);
  import sesm_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ENABLE   = 4'd1;
  localparam logic [3:0] PH_W_DATA   = 4'd2;
  localparam logic [3:0] PH_W_HIGH   = 4'd3;
  localparam logic [3:0] PH_W_LOW    = 4'd4;
  localparam logic [3:0] PH_RD_SETUP = 4'd5;
  localparam logic [3:0] PH_R_HIGH   = 4'd6;
  localparam logic [3:0] PH_R_LOW    = 4'd7;
  localparam logic [3:0] PH_END_WAIT = 4'd8;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BITS);
  localparam logic [TICK_W-1:0] PT_RESET = TICK_W'(16);

  logic [TICK_W-1:0] phase_ticks_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  bit_r, bit_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  rtot_r, rtot_nxt;
  logic [CNT_W-1:0]  wtot_r, wtot_nxt;
  logic [CMD_W-1:0]  acc_r, acc_nxt;
  logic [2:0]        pins_r, pins_nxt;

  logic [TICK_W-1:0] enter_ticks;
  logic [CNT_W-1:0]  bit_inc;
  logic              done;
  logic [CMD_W-1:0]  value;

  // A phase lasts phase_ticks ticks; zero counts as one.
  assign enter_ticks = (phase_ticks_r == '0) ? '0 : phase_ticks_r - TICK_W'(1);
  assign bit_inc     = bit_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    cmd_nxt   = cmd_r;
    rtot_nxt  = rtot_r;
    wtot_nxt  = wtot_r;
    acc_nxt   = acc_r;
    pins_nxt  = pins_r;
    done      = 1'b0;
    value     = '0;
    if (phase_r == PH_IDLE) begin
      if (item_i.start_req) begin
        cmd_nxt   = item_i.command_word;
        wtot_nxt  = (item_i.write_count > MAX_CNT) ? MAX_CNT : item_i.write_count;
        rtot_nxt  = (item_i.read_count > MAX_CNT) ? MAX_CNT : item_i.read_count;
        bit_nxt   = '0;
        acc_nxt   = '0;
        pins_nxt  = 3'b000;
        pins_nxt[PIN_CE] = 1'b1;
        phase_nxt = PH_ENABLE;
        tick_nxt  = enter_ticks;
      end
    end else if (tick_r != '0) begin
      tick_nxt = tick_r - TICK_W'(1);
    end else begin
      case (phase_r)
        PH_ENABLE: begin
          bit_nxt  = '0;
          tick_nxt = enter_ticks;
          if (wtot_r != '0) begin
            pins_nxt[PIN_DI] = cmd_r[0];
            phase_nxt = PH_W_DATA;
          end else begin
            pins_nxt[PIN_DI] = 1'b1;
            phase_nxt = PH_RD_SETUP;
          end
        end
        PH_W_DATA: begin
          pins_nxt[PIN_SK] = 1'b1;
          phase_nxt = PH_W_HIGH;
          tick_nxt  = enter_ticks;
        end
        PH_W_HIGH: begin
          pins_nxt[PIN_SK] = 1'b0;
          phase_nxt = PH_W_LOW;
          tick_nxt  = enter_ticks;
        end
        PH_W_LOW: begin
          cmd_nxt  = {1'b0, cmd_r[CMD_W-1:1]};
          bit_nxt  = bit_inc;
          tick_nxt = enter_ticks;
          if (bit_inc < wtot_r) begin
            // Next command bit is the one just shifted down.
            pins_nxt[PIN_DI] = cmd_r[1];
            phase_nxt = PH_W_DATA;
          end else begin
            pins_nxt[PIN_DI] = 1'b1;
            phase_nxt = PH_RD_SETUP;
          end
        end
        PH_RD_SETUP: begin
          bit_nxt  = '0;
          tick_nxt = enter_ticks;
          if (rtot_r != '0) begin
            acc_nxt[0] = acc_r[0] | item_i.serial_data_out;
            pins_nxt[PIN_SK] = 1'b1;
            phase_nxt = PH_R_HIGH;
          end else begin
            phase_nxt = PH_END_WAIT;
          end
        end
        PH_R_HIGH: begin
          pins_nxt[PIN_SK] = 1'b0;
          phase_nxt = PH_R_LOW;
          tick_nxt  = enter_ticks;
        end
        PH_R_LOW: begin
          bit_nxt  = bit_inc;
          tick_nxt = enter_ticks;
          if (bit_inc < rtot_r) begin
            // Samples past the top of the value register are dropped.
            if (item_i.serial_data_out && bit_inc < CNT_W'(CMD_W)) begin
              acc_nxt[bit_inc[3:0]] = 1'b1;
            end
            pins_nxt[PIN_SK] = 1'b1;
            phase_nxt = PH_R_HIGH;
          end else begin
            phase_nxt = PH_END_WAIT;
          end
        end
        default: begin
          pins_nxt[PIN_CE] = 1'b0;
          done      = 1'b1;
          value     = acc_r;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PT_RESET;
      phase_r       <= PH_IDLE;
      tick_r        <= '0;
      bit_r         <= '0;
      cmd_r         <= '0;
      rtot_r        <= '0;
      wtot_r        <= '0;
      acc_r         <= '0;
      pins_r        <= '0;
    end else begin
      if (cfg_we) begin
        phase_ticks_r <= cfg_wdata;
      end
      if (step_i) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        cmd_r   <= cmd_nxt;
        rtot_r  <= rtot_nxt;
        wtot_r  <= wtot_nxt;
        acc_r   <= acc_nxt;
        pins_r  <= pins_nxt;
      end
    end
  end

  always_comb begin
    res_o.serial_clock   = pins_nxt[PIN_SK];
    res_o.serial_data_in = pins_nxt[PIN_DI];
    res_o.chip_enable    = pins_nxt[PIN_CE];
    res_o.busy_res       = (phase_nxt != PH_IDLE);
    res_o.done_res       = done;
    res_o.read_value     = value;
  end

  `SESM_ASSERT_IMPLIES(a_idle_pins_quiet, phase_r == PH_IDLE,
                       !pins_r[PIN_CE] && !pins_r[PIN_SK], "pins active while idle")
  `SESM_ASSERT_NEXT(a_start_enables, step_i && phase_r == PH_IDLE && item_i.start_req,
                    phase_r == PH_ENABLE && pins_r == 3'b100, "start did not enable chip")
endmodule

`default_nettype wire
